FILE: hdl/sv32ptw_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sv32ptw_pkg
// Shared types, codes and constants of the Sv32 page table walker.
// ============================================================================
package sv32ptw_pkg;

    // field widths
    localparam int VA_W       = 32;
    localparam int PA_W       = 34;
    localparam int PTE_W      = 32;
    localparam int PPN_W      = 22;
    localparam int VPN_W      = 10;
    localparam int OFFSET_W   = 12;
    localparam int FAULT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    // PTE bit positions
    localparam int PTE_V_BIT = 0;
    localparam int PTE_R_BIT = 1;
    localparam int PTE_W_BIT = 2;
    localparam int PTE_X_BIT = 3;
    localparam int PTE_U_BIT = 4;
    localparam int PTE_A_BIT = 6;
    localparam int PTE_D_BIT = 7;

    typedef enum logic [1:0] {
        ACT_TRANSLATE = 2'd0,
        ACT_READ_RSP  = 2'd1,
        ACT_WRITE_RSP = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ACC_FETCH = 2'd0,
        ACC_LOAD  = 2'd1,
        ACC_STORE = 2'd2,
        ACC_OTHER = 2'd3
    } access_t;

    // effective privilege after mapping (code 2 folds into user)
    typedef enum logic [1:0] {
        PRIV_USER    = 2'd0,
        PRIV_SUPER   = 2'd1,
        PRIV_RSVD    = 2'd2,
        PRIV_MACHINE = 2'd3
    } priv_t;

    typedef enum logic [1:0] {
        KIND_READ       = 2'd0,
        KIND_WRITE      = 2'd1,
        KIND_DONE       = 2'd2,
        KIND_UNEXPECTED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_READY        = 2'd0,
        ST_PAGE_FAULT   = 2'd1,
        ST_ACCESS_FAULT = 2'd2,
        ST_UNUSED       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        REG_CUR_PRIV  = 3'd0,
        REG_XLATE_EN  = 3'd1,
        REG_ROOT_PPN  = 3'd2,
        REG_SUM       = 3'd3,
        REG_MXR       = 3'd4,
        REG_MPRV      = 3'd5,
        REG_PREV_PRIV = 3'd6,
        REG_NONE      = 3'd7
    } cfg_idx_t;

    // walk phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_READ  = 3'b010,
        PH_WRITE = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]        cur_priv;
        logic              xlate_en;
        logic [PPN_W-1:0]  root_ppn;
        logic              sum;
        logic              mxr;
        logic              mprv;
        logic [1:0]        prev_priv;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [VA_W-1:0]    virt_addr;
        logic [1:0]         access_type;
        logic [PTE_W-1:0]   response_data;
        logic [FAULT_W-1:0] response_fault;
    } item_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [PA_W-1:0]    mem_address;
        logic [PTE_W-1:0]   mem_write_data;
        logic [1:0]         status;
        logic [PA_W-1:0]    phys_addr;
        logic [FAULT_W-1:0] fault_code;
    } result_t;

    // control part of the walk state (reset)
    typedef struct packed {
        phase_t phase;
        logic   level;
    } walk_ctl_t;

    // held part of the walk state (no reset)
    typedef struct packed {
        logic [VA_W-1:0] va;
        logic [1:0]      access;
        logic [1:0]      priv;
        logic [PA_W-1:0] entry_addr;
        logic [PA_W-1:0] pending_pa;
    } walk_hold_t;

    function automatic priv_t map_priv(input logic [1:0] p);
        priv_t r;
        case (p)
            2'd1:    r = PRIV_SUPER;
            2'd3:    r = PRIV_MACHINE;
            default: r = PRIV_USER;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/sv32ptw_if.sv
`timescale 1ns / 1ps
// ============================================================================
// sv32ptw interfaces
// Valid/ready channels: walker items, walker results, configuration writes.
// ============================================================================
interface sv32ptw_item_if import sv32ptw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [VA_W-1:0]    virt_addr;
    logic [1:0]         access_type;
    logic [PTE_W-1:0]   response_data;
    logic [FAULT_W-1:0] response_fault;

    modport source (output valid, action, virt_addr, access_type,
                    response_data, response_fault, input ready);
    modport sink   (input valid, action, virt_addr, access_type,
                    response_data, response_fault, output ready);
endinterface

interface sv32ptw_result_if import sv32ptw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         result_kind;
    logic [PA_W-1:0]    mem_address;
    logic [PTE_W-1:0]   mem_write_data;
    logic [1:0]         status;
    logic [PA_W-1:0]    phys_addr;
    logic [FAULT_W-1:0] fault_code;

    modport source (output valid, result_kind, mem_address, mem_write_data, status,
                    phys_addr, fault_code, input ready);
    modport sink   (input valid, result_kind, mem_address, mem_write_data, status,
                    phys_addr, fault_code, output ready);
endinterface

interface sv32ptw_cfg_if import sv32ptw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/sv32ptw_cfg_regs.sv
`timescale 1ns / 1ps
// ============================================================================
// sv32ptw_cfg_regs
// Configuration register file; always ready, writes land at the handshake.
// ============================================================================
module sv32ptw_cfg_regs import sv32ptw_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    sv32ptw_cfg_if.sink cfg,
    output cfg_t       cfg_out
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_CUR_PRIV:  cfg_next.cur_priv  = cfg.data[1:0];
                REG_XLATE_EN:  cfg_next.xlate_en  = cfg.data[0];
                REG_ROOT_PPN:  cfg_next.root_ppn  = cfg.data[PPN_W-1:0];
                REG_SUM:       cfg_next.sum       = cfg.data[0];
                REG_MXR:       cfg_next.mxr       = cfg.data[0];
                REG_MPRV:      cfg_next.mprv      = cfg.data[0];
                REG_PREV_PRIV: cfg_next.prev_priv = cfg.data[1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cur_priv  <= PRIV_MACHINE;
            cfg_reg.xlate_en  <= 1'b0;
            cfg_reg.root_ppn  <= '0;
            cfg_reg.sum       <= 1'b0;
            cfg_reg.mxr       <= 1'b0;
            cfg_reg.mprv      <= 1'b0;
            cfg_reg.prev_priv <= PRIV_USER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: hdl/sv32ptw_step.sv
`timescale 1ns / 1ps
// ============================================================================
// sv32ptw_step
// One walker decision: item plus walk state give one result and next state.
// ============================================================================
module sv32ptw_step import sv32ptw_pkg::*; (
    input  item_t      item,
    input  cfg_t       cfg,
    input  walk_ctl_t  ctl,
    input  walk_hold_t hold,
    output result_t    res,
    output walk_ctl_t  ctl_next,
    output walk_hold_t hold_next
);

    priv_t            eff_priv;
    logic [PTE_W-1:0] pte;
    logic [PPN_W-1:0] ppn;
    logic [PA_W-1:0]  leaf_pa;
    logic [PTE_W-1:0] pte_upd;
    logic             pte_user;
    logic             permit;
    logic             perm_type;

    assign pte      = item.response_data;
    assign ppn      = pte[PTE_W-1:VPN_W];
    assign pte_user = pte[PTE_U_BIT];

    always_comb
    begin
        if (item.access_type == ACC_FETCH || !cfg.mprv)
            eff_priv = map_priv(cfg.cur_priv);
        else
            eff_priv = map_priv(cfg.prev_priv);
    end

    // U / SUM / MXR permission check against the held request
    always_comb
    begin
        case (access_t'(hold.access))
            ACC_FETCH: perm_type = pte[PTE_X_BIT];
            ACC_LOAD:  perm_type = pte[PTE_R_BIT] | (cfg.mxr & pte[PTE_X_BIT]);
            ACC_STORE: perm_type = pte[PTE_W_BIT];
            default:   perm_type = 1'b0;
        endcase
        permit = perm_type;
        if (hold.priv == PRIV_USER && !pte_user)
            permit = 1'b0;
        if (hold.priv == PRIV_SUPER && pte_user &&
            (hold.access == ACC_FETCH || !cfg.sum))
            permit = 1'b0;
    end

    // superpage keeps vpn0 from the virtual address
    always_comb
    begin
        if (ctl.level)
            leaf_pa = {ppn[PPN_W-1:VPN_W], hold.va[OFFSET_W+VPN_W-1:0]};
        else
            leaf_pa = {ppn, hold.va[OFFSET_W-1:0]};
        pte_upd = pte;
        pte_upd[PTE_A_BIT] = 1'b1;
        if (hold.access == ACC_STORE)
            pte_upd[PTE_D_BIT] = 1'b1;
    end

    always_comb
    begin
        res       = '0;
        ctl_next  = ctl;
        hold_next = hold;
        res.result_kind = KIND_UNEXPECTED;

        if (item.action == ACT_TRANSLATE && ctl.phase == PH_IDLE)
        begin
            if (eff_priv == PRIV_MACHINE || !cfg.xlate_en)
            begin
                res.result_kind = KIND_DONE;
                res.status      = ST_READY;
                res.phys_addr   = {2'b00, item.virt_addr};
                ctl_next.level  = 1'b0;
            end
            else
            begin
                hold_next.va         = item.virt_addr;
                hold_next.access     = item.access_type;
                hold_next.priv       = eff_priv;
                hold_next.entry_addr = {cfg.root_ppn,
                                        item.virt_addr[VA_W-1:VA_W-VPN_W], 2'b00};
                ctl_next.level       = 1'b1;
                ctl_next.phase       = PH_READ;
                res.result_kind      = KIND_READ;
                res.mem_address      = hold_next.entry_addr;
            end
        end
        else if (item.action == ACT_READ_RSP && ctl.phase == PH_READ)
        begin
            res.result_kind = KIND_DONE;
            ctl_next.phase  = PH_IDLE;
            ctl_next.level  = 1'b0;
            if (item.response_fault != '0)
            begin
                res.status     = ST_ACCESS_FAULT;
                res.fault_code = item.response_fault;
            end
            else if (!pte[PTE_V_BIT] || (!pte[PTE_R_BIT] && pte[PTE_W_BIT]))
            begin
                res.status = ST_PAGE_FAULT;
            end
            else if (!pte[PTE_R_BIT] && !pte[PTE_X_BIT])
            begin
                // pointer to the next level
                if (pte[PTE_U_BIT] || pte[PTE_A_BIT] || pte[PTE_D_BIT] || !ctl.level)
                begin
                    res.status = ST_PAGE_FAULT;
                end
                else
                begin
                    hold_next.entry_addr = {ppn, hold.va[OFFSET_W+VPN_W-1:OFFSET_W], 2'b00};
                    ctl_next.phase       = PH_READ;
                    res.result_kind      = KIND_READ;
                    res.mem_address      = hold_next.entry_addr;
                end
            end
            else if ((ctl.level && ppn[VPN_W-1:0] != '0) || !permit)
            begin
                res.status = ST_PAGE_FAULT;
            end
            else if (pte_upd != pte)
            begin
                hold_next.pending_pa = leaf_pa;
                ctl_next.phase       = PH_WRITE;
                ctl_next.level       = ctl.level;
                res.result_kind      = KIND_WRITE;
                res.mem_address      = hold.entry_addr;
                res.mem_write_data   = pte_upd;
            end
            else
            begin
                res.status    = ST_READY;
                res.phys_addr = leaf_pa;
            end
        end
        else if (item.action == ACT_WRITE_RSP && ctl.phase == PH_WRITE)
        begin
            res.result_kind = KIND_DONE;
            ctl_next.phase  = PH_IDLE;
            ctl_next.level  = 1'b0;
            if (item.response_fault != '0)
            begin
                res.status     = ST_ACCESS_FAULT;
                res.fault_code = item.response_fault;
            end
            else
            begin
                res.status    = ST_READY;
                res.phys_addr = hold.pending_pa;
            end
        end
    end

endmodule

FILE: hdl/sv32_page_table_walker_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// sv32_page_table_walker_unit
// Sv32 two-level page table walker stepped by requests and PTE responses.
// ============================================================================
//
//  Channel  Dir  Payload                                         Transaction
//  -------  ---  ----------------------------------------------  ------------------
//  req      in   action, virt_addr, access_type,                 valid & ready
//                response_data, response_fault
//  rsp      out  result_kind, mem_address, mem_write_data,       valid & ready
//                status, phys_addr, fault_code
//  cfg      in   index, data (register write)                    valid & ready
//
//  Throughput: one transaction per cycle on req while rsp is not stalled; every req
//  transaction makes exactly one rsp transaction. A req transaction passes
//  through the input register and then the result register; the walker
//  decision logic sits between them and updates the walk state.
//  Reset clears walk phase/level, both valid flags and config registers.
//  A stall on rsp holds the result register; req stays ready while the input
//  register is empty or about to move into the result register.
//
module sv32_page_table_walker_unit import sv32ptw_pkg::*; (
    input  logic            clk,
    input  logic            rst_n,
    sv32ptw_item_if.sink    req,
    sv32ptw_result_if.source rsp,
    sv32ptw_cfg_if.sink     cfg
);

    cfg_t       cfg_val;

    // input stage
    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;

    // result stage
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    out_res_reg;

    // walk state
    walk_ctl_t  ctl_reg;
    walk_ctl_t  ctl_next;
    walk_hold_t hold_reg;
    walk_hold_t hold_next;

    result_t    step_res;
    logic       advance;
    logic       req_xact;

    sv32ptw_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_val)
    );

    sv32ptw_step u_step (
        .item      (in_item_reg),
        .cfg       (cfg_val),
        .ctl       (ctl_reg),
        .hold      (hold_reg),
        .res       (step_res),
        .ctl_next  (ctl_next),
        .hold_next (hold_next)
    );

    // the held item is decided when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_xact  = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (advance)
            in_valid_next = 1'b0;
        if (req_xact)
            in_valid_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (rsp.ready)
            out_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg.phase <= PH_IDLE;
            ctl_reg.level <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                ctl_reg <= ctl_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (req_xact)
        begin
            in_item_reg.action         <= req.action;
            in_item_reg.virt_addr      <= req.virt_addr;
            in_item_reg.access_type    <= req.access_type;
            in_item_reg.response_data  <= req.response_data;
            in_item_reg.response_fault <= req.response_fault;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
            hold_reg    <= hold_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.result_kind    = out_res_reg.result_kind;
    assign rsp.mem_address    = out_res_reg.mem_address;
    assign rsp.mem_write_data = out_res_reg.mem_write_data;
    assign rsp.status         = out_res_reg.status;
    assign rsp.phys_addr      = out_res_reg.phys_addr;
    assign rsp.fault_code     = out_res_reg.fault_code;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for sv32_page_table_walker_unit. A directed stimulus
// table comes first, then random phases, each with its own register setting.
// The bench plays the memory side of the walker. Every accepted transaction
// goes through a behavioral walk model, and every result is checked in order.
// ============================================================================
module tb;
    import sv32ptw_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_PRINTED     = 50;

    // One row of the directed part: either a register write or a request
    // transaction, optionally with a hand-typed expected result.
    typedef struct {
        bit                    is_reg;
        cfg_idx_t              reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        item_t                 item;
        bit                    known;
        result_t               want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    sv32ptw_item_if   req_if ();
    sv32ptw_result_if rsp_if ();
    sv32ptw_cfg_if    cfg_if ();

    sv32_page_table_walker_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Walk model state: register copy plus the walker's own state
    // ------------------------------------------------------------------------
    cfg_t            walk_cfg;
    phase_t          walk_phase;
    logic            walk_lvl;
    logic [VA_W-1:0] held_va;
    access_t         held_acc;
    priv_t           held_priv;
    logic [PA_W-1:0] pte_addr;
    logic [PA_W-1:0] held_pa;

    // results owed by the walker, oldest first
    result_t walk_results_due[$];

    // hand-typed expectation riding along with the current request
    logic    row_known;
    result_t row_want;

    // run bookkeeping
    int mismatches;
    int items_in;
    int useful_items;   // requests that were not rejected as out of order
    int results_out;
    int reg_writes;
    int kind_seen[4];
    int page_faults;
    int access_faults;
    int quiet_cycles;   // cycles without any transaction, for the watchdog
    bit calm;           // no idling on either side during this phase

    // ------------------------------------------------------------------------
    // Walk model
    // ------------------------------------------------------------------------
    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CUR_PRIV:  walk_cfg.cur_priv  = val[1:0];
            REG_XLATE_EN:  walk_cfg.xlate_en  = val[0];
            REG_ROOT_PPN:  walk_cfg.root_ppn  = val[PPN_W-1:0];
            REG_SUM:       walk_cfg.sum       = val[0];
            REG_MXR:       walk_cfg.mxr       = val[0];
            REG_MPRV:      walk_cfg.mprv      = val[0];
            REG_PREV_PRIV: walk_cfg.prev_priv = val[1:0];
            default: ;
        endcase
    endfunction

    // U/SUM/MXR rules for the leaf; SUM and MXR are taken as they are now
    function automatic bit leaf_allows(input logic [PTE_W-1:0] pte);
        bit ok;
        ok = 1'b1;
        if (held_priv == PRIV_USER && !pte[PTE_U_BIT])
            ok = 1'b0;
        if (held_priv == PRIV_SUPER && pte[PTE_U_BIT] &&
            (held_acc == ACC_FETCH || !walk_cfg.sum))
            ok = 1'b0;
        case (held_acc)
            ACC_FETCH: ok = ok && pte[PTE_X_BIT];
            ACC_LOAD:  ok = ok && (pte[PTE_R_BIT] || (walk_cfg.mxr && pte[PTE_X_BIT]));
            ACC_STORE: ok = ok && pte[PTE_W_BIT];
            default:   ok = 1'b0;   // the fourth access type never passes
        endcase
        return ok;
    endfunction

    function automatic result_t walk_done(input status_t st, input logic [PA_W-1:0] pa,
                                          input logic [FAULT_W-1:0] bf);
        result_t r;
        r             = '0;
        r.result_kind = KIND_DONE;
        r.status      = st;
        r.phys_addr   = pa;
        r.fault_code  = bf;
        walk_phase    = PH_IDLE;
        walk_lvl      = 1'b0;
        return r;
    endfunction

    // One decision of the walker on one request transaction
    function automatic result_t next_walk_result(input item_t it);
        result_t          r;
        logic [1:0]       eff;
        priv_t            p;
        logic [PTE_W-1:0] pte;
        logic [PPN_W-1:0] ppn;
        logic [PA_W-1:0]  pa;
        logic [PTE_W-1:0] upd;
        r             = '0;
        r.result_kind = KIND_UNEXPECTED;
        pte           = it.response_data;
        ppn           = pte[PTE_W-1:10];
        if (it.action == ACT_TRANSLATE && walk_phase == PH_IDLE)
        begin
            // MPRV swaps in MPP for every access type but fetches
            eff = (it.access_type == ACC_FETCH || !walk_cfg.mprv) ?
                  walk_cfg.cur_priv : walk_cfg.prev_priv;
            case (eff)
                2'd1:    p = PRIV_SUPER;
                2'd3:    p = PRIV_MACHINE;
                default: p = PRIV_USER;
            endcase
            if (p == PRIV_MACHINE || !walk_cfg.xlate_en)
                r = walk_done(ST_READY, {2'b00, it.virt_addr}, '0);
            else
            begin
                held_va       = it.virt_addr;
                held_acc      = access_t'(it.access_type);
                held_priv     = p;
                walk_lvl      = 1'b1;
                pte_addr      = {walk_cfg.root_ppn, 12'h000} +
                                {22'd0, it.virt_addr[31:22], 2'b00};
                walk_phase    = PH_READ;
                r.result_kind = KIND_READ;
                r.mem_address = pte_addr;
            end
        end
        else if (it.action == ACT_READ_RSP && walk_phase == PH_READ)
        begin
            if (it.response_fault != '0)
                r = walk_done(ST_ACCESS_FAULT, '0, it.response_fault);
            else if (!pte[PTE_V_BIT] || (!pte[PTE_R_BIT] && pte[PTE_W_BIT]))
                r = walk_done(ST_PAGE_FAULT, '0, '0);
            else if (!pte[PTE_R_BIT] && !pte[PTE_X_BIT])
            begin
                // pointer: only legal at the root level and with U/A/D clear
                if (pte[PTE_U_BIT] || pte[PTE_A_BIT] || pte[PTE_D_BIT] || !walk_lvl)
                    r = walk_done(ST_PAGE_FAULT, '0, '0);
                else
                begin
                    walk_lvl      = 1'b0;
                    pte_addr      = {ppn, 12'h000} + {22'd0, held_va[21:12], 2'b00};
                    r.result_kind = KIND_READ;
                    r.mem_address = pte_addr;
                end
            end
            else if (walk_lvl && ppn[VPN_W-1:0] != '0)
                r = walk_done(ST_PAGE_FAULT, '0, '0);     // misaligned superpage
            else if (!leaf_allows(pte))
                r = walk_done(ST_PAGE_FAULT, '0, '0);
            else
            begin
                pa  = walk_lvl ? {ppn[PPN_W-1:10], held_va[21:12], held_va[11:0]} :
                                 {ppn, held_va[11:0]};
                upd = pte;
                upd[PTE_A_BIT] = 1'b1;
                if (held_acc == ACC_STORE)
                    upd[PTE_D_BIT] = 1'b1;
                if (upd != pte)
                begin
                    held_pa          = pa;
                    walk_phase       = PH_WRITE;
                    r.result_kind    = KIND_WRITE;
                    r.mem_address    = pte_addr;
                    r.mem_write_data = upd;
                end
                else
                    r = walk_done(ST_READY, pa, '0);
            end
        end
        else if (it.action == ACT_WRITE_RSP && walk_phase == PH_WRITE)
        begin
            if (it.response_fault != '0)
                r = walk_done(ST_ACCESS_FAULT, '0, it.response_fault);
            else
                r = walk_done(ST_READY, held_pa, '0);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h",
                     $time, what, got, want);
    endtask

    task automatic compare_result(input result_t got, input result_t want);
        if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", got.result_kind, want.result_kind);
        if (got.mem_address !== want.mem_address)
            report_mismatch("mem_address", got.mem_address, want.mem_address);
        if (got.mem_write_data !== want.mem_write_data)
            report_mismatch("mem_write_data", got.mem_write_data, want.mem_write_data);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.phys_addr !== want.phys_addr)
            report_mismatch("phys_addr", got.phys_addr, want.phys_addr);
        if (got.fault_code !== want.fault_code)
            report_mismatch("fault_code", got.fault_code, want.fault_code);
    endtask

    // Everything is sampled at the rising edge; the bench drives on the
    // falling edge, so all values here are settled.
    always @(posedge clk)
    begin : monitor
        item_t   it;
        result_t got;
        result_t pred;
        bit      moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                apply_reg(cfg_if.index, cfg_if.data);
                reg_writes++;
                moved = 1'b1;
            end
            if (req_if.valid && req_if.ready)
            begin
                it.action         = req_if.action;
                it.virt_addr      = req_if.virt_addr;
                it.access_type    = req_if.access_type;
                it.response_data  = req_if.response_data;
                it.response_fault = req_if.response_fault;
                // the model always runs so that its state follows the block
                pred = next_walk_result(it);
                if (pred.result_kind != KIND_UNEXPECTED)
                    useful_items++;
                items_in++;
                walk_results_due.push_back(row_known ? row_want : pred);
                moved = 1'b1;
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.result_kind    = rsp_if.result_kind;
                got.mem_address    = rsp_if.mem_address;
                got.mem_write_data = rsp_if.mem_write_data;
                got.status         = rsp_if.status;
                got.phys_addr      = rsp_if.phys_addr;
                got.fault_code     = rsp_if.fault_code;
                results_out++;
                moved = 1'b1;
                if (walk_results_due.size() == 0)
                    report_mismatch("result with nothing awaited", got.result_kind, '0);
                else
                begin
                    pred = walk_results_due.pop_front();
                    compare_result(got, pred);
                end
                kind_seen[got.result_kind]++;
                if (got.result_kind == KIND_DONE && got.status == ST_PAGE_FAULT)
                    page_faults++;
                if (got.result_kind == KIND_DONE && got.status == ST_ACCESS_FAULT)
                    access_faults++;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Idling and the memory side
    // ------------------------------------------------------------------------
    // mostly no gap, often a short one, rarely a long one
    function automatic int idle_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Result side backpressure
    initial
    begin : result_sink
        int hold;
        hold         = 0;
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                hold = calm ? 0 : idle_gap();
            end
        end
    end

    // PTE returned for a read request: mostly valid pointers at the root
    // level and leaves, with aligned superpages favored; some raw noise.
    function automatic logic [PTE_W-1:0] make_pte();
        logic [PTE_W-1:0] pte;
        int               roll;
        pte  = $urandom;
        roll = $urandom_range(0, 99);
        if (roll >= 10)
        begin
            pte[PTE_V_BIT] = 1'b1;
            if (roll < 40 && (walk_lvl || roll < 14))
            begin
                pte[PTE_R_BIT] = 1'b0;
                pte[PTE_W_BIT] = 1'b0;
                pte[PTE_X_BIT] = 1'b0;
                if ($urandom_range(0, 7) != 0)
                begin
                    pte[PTE_U_BIT] = 1'b0;
                    pte[PTE_A_BIT] = 1'b0;
                    pte[PTE_D_BIT] = 1'b0;
                end
            end
            else
            begin
                if (!pte[PTE_R_BIT] && !pte[PTE_X_BIT])
                    pte[$urandom_range(0, 1) ? PTE_R_BIT : PTE_X_BIT] = 1'b1;
                if (pte[PTE_W_BIT] && !pte[PTE_R_BIT] && $urandom_range(0, 1))
                    pte[PTE_R_BIT] = 1'b1;
                if (walk_lvl && $urandom_range(0, 3) != 0)
                    pte[19:10] = '0;
            end
        end
        return pte;
    endfunction

    // Next request: the transaction the walker waits for, with random
    // content, or (when noise is allowed) now and then anything at all.
    function automatic item_t pick_item(input bit allow_noise);
        item_t it;
        it.action         = ACT_TRANSLATE;
        it.virt_addr      = $urandom;
        it.response_data  = $urandom;
        it.response_fault = FAULT_W'($urandom);
        it.access_type    = ($urandom_range(0, 15) == 0) ? ACC_OTHER :
                            2'($urandom_range(0, 2));
        if (allow_noise && $urandom_range(0, 99) < 8)
            it.action = 2'($urandom_range(0, 3));
        else
        begin
            case (walk_phase)
                PH_READ:
                begin
                    it.action        = ACT_READ_RSP;
                    it.response_data = make_pte();
                end
                PH_WRITE: it.action = ACT_WRITE_RSP;
                default:  it.action = ACT_TRANSLATE;
            endcase
            if ($urandom_range(0, 9) != 0)
                it.response_fault = '0;
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers; each is entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input item_t it, input bit known, input result_t want);
        int gap;
        gap = calm ? 0 : idle_gap();
        cfg_if.valid <= 1'b0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid          <= 1'b1;
        req_if.action         <= it.action;
        req_if.virt_addr      <= it.virt_addr;
        req_if.access_type    <= it.access_type;
        req_if.response_data  <= it.response_data;
        req_if.response_fault <= it.response_fault;
        row_known             <= known;
        row_want              <= want;
        do @(posedge clk); while (!req_if.ready);
        @(negedge clk);
    endtask

    // Register writes only go out once every owed result has come back
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        req_if.valid <= 1'b0;
        if (walk_results_due.size() != 0)
        begin
            cfg_if.valid <= 1'b0;
            while (walk_results_due.size() != 0) @(negedge clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------------
    function automatic stim_row_t reg_row(input cfg_idx_t idx,
                                          input logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.item    = '0;
        r.known   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic stim_row_t item_row(input action_t act, input logic [VA_W-1:0] va,
                                           input access_t acc, input logic [PTE_W-1:0] pte,
                                           input logic [FAULT_W-1:0] fault);
        stim_row_t r;
        r.is_reg              = 1'b0;
        r.reg_idx             = REG_NONE;
        r.reg_val             = '0;
        r.item.action         = act;
        r.item.virt_addr      = va;
        r.item.access_type    = acc;
        r.item.response_data  = pte;
        r.item.response_fault = fault;
        r.known               = 1'b0;
        r.want                = '0;
        return r;
    endfunction

    function automatic stim_row_t known_row(input stim_row_t base, input kind_t kind,
                                            input logic [PA_W-1:0] mem, input status_t st,
                                            input logic [PA_W-1:0] pa,
                                            input logic [FAULT_W-1:0] bf);
        stim_row_t r;
        r                  = base;
        r.known            = 1'b1;
        r.want             = '0;
        r.want.result_kind = kind;
        r.want.mem_address = mem;
        r.want.status      = st;
        r.want.phys_addr   = pa;
        r.want.fault_code  = bf;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        stim_row_t         rows[$];
        result_t           none;
        int                target;
        logic [1:0]        cp;
        logic [1:0]        pp;
        logic [PPN_W-1:0]  root;
        bit                en;
        bit                s;
        bit                m;
        bit                mp;

        clk                   = 1'b0;
        rst_n                 = 1'b0;
        calm                  = 1'b0;
        none                  = '0;
        req_if.valid          = 1'b0;
        req_if.action         = ACT_TRANSLATE;
        req_if.virt_addr      = '0;
        req_if.access_type    = ACC_FETCH;
        req_if.response_data  = '0;
        req_if.response_fault = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = REG_CUR_PRIV;
        cfg_if.data           = '0;
        row_known             = 1'b0;
        row_want              = '0;
        mismatches            = 0;
        items_in              = 0;
        useful_items          = 0;
        results_out           = 0;
        reg_writes            = 0;
        kind_seen             = '{default: 0};
        page_faults           = 0;
        access_faults         = 0;
        quiet_cycles          = 0;

        // state after reset: machine mode, translation off
        walk_cfg          = '0;
        walk_cfg.cur_priv = 2'd3;
        walk_phase        = PH_IDLE;
        walk_lvl          = 1'b0;
        held_va           = '0;
        held_acc          = ACC_FETCH;
        held_priv         = PRIV_USER;
        pte_addr          = '0;
        held_pa           = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // -- directed part ---------------------------------------------------
        // reset setting: everything passes straight through
        rows.push_back(known_row(item_row(ACT_TRANSLATE, 32'hFFFF_FFFF, ACC_FETCH,
                                          32'hFFFF_FFFF, 3'd0),
                                 KIND_DONE, '0, ST_READY, 34'h0_FFFF_FFFF, '0));
        rows.push_back(known_row(item_row(ACT_TRANSLATE, 32'h0, ACC_STORE, 32'h0, 3'd7),
                                 KIND_DONE, '0, ST_READY, '0, '0));
        // out-of-order transactions with the walker idle
        rows.push_back(known_row(item_row(ACT_READ_RSP, 32'h0, ACC_LOAD,
                                          32'hFFFF_FFFF, 3'd7),
                                 KIND_UNEXPECTED, '0, ST_READY, '0, '0));
        rows.push_back(known_row(item_row(ACT_WRITE_RSP, 32'hFFFF_FFFF, ACC_OTHER,
                                          32'h0, 3'd0),
                                 KIND_UNEXPECTED, '0, ST_READY, '0, '0));
        rows.push_back(known_row(item_row(ACT_NONE, 32'h1234_5678, ACC_LOAD,
                                          32'h0000_0001, 3'd0),
                                 KIND_UNEXPECTED, '0, ST_READY, '0, '0));
        // supervisor with Sv32, root table at the top of physical memory
        rows.push_back(reg_row(REG_CUR_PRIV, 22'd1));
        rows.push_back(reg_row(REG_XLATE_EN, 22'd1));
        rows.push_back(reg_row(REG_ROOT_PPN, 22'h3F_FFFF));
        rows.push_back(known_row(item_row(ACT_TRANSLATE, 32'hFFFF_F123, ACC_LOAD,
                                          32'h0, 3'd0),
                                 KIND_READ, 34'h3_FFFF_FFFC, ST_READY, '0, '0));
        // busy walker: a new translate and a write response are both rejected
        rows.push_back(known_row(item_row(ACT_TRANSLATE, 32'h0, ACC_FETCH, 32'h0, 3'd0),
                                 KIND_UNEXPECTED, '0, ST_READY, '0, '0));
        rows.push_back(known_row(item_row(ACT_WRITE_RSP, 32'h0, ACC_FETCH, 32'h0, 3'd0),
                                 KIND_UNEXPECTED, '0, ST_READY, '0, '0));
        // bus error on the PTE read
        rows.push_back(known_row(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH,
                                          32'hFFFF_FFFF, 3'd7),
                                 KIND_DONE, '0, ST_ACCESS_FAULT, '0, 3'd7));
        // full two-level walk, leaf already accessed and dirty
        rows.push_back(item_row(ACT_TRANSLATE, 32'h0040_0000, ACC_STORE, 32'h0, 3'd0));
        rows.push_back(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH, 32'hFFFF_FC01, 3'd0));
        rows.push_back(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH, 32'hFFFF_FCC7, 3'd0));
        // supervisor fetch from a user superpage
        rows.push_back(item_row(ACT_TRANSLATE, 32'h1234_5678, ACC_FETCH, 32'h0, 3'd0));
        rows.push_back(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH, 32'h0040_001F, 3'd0));
        // PTE not valid
        rows.push_back(item_row(ACT_TRANSLATE, 32'h8000_0000, ACC_LOAD, 32'h0, 3'd0));
        rows.push_back(known_row(item_row(ACT_READ_RSP, 32'h0, ACC_LOAD, 32'h0, 3'd0),
                                 KIND_DONE, '0, ST_PAGE_FAULT, '0, '0));
        // fourth access type: nothing grants it
        rows.push_back(item_row(ACT_TRANSLATE, 32'h7FFF_FFFF, ACC_OTHER, 32'h0, 3'd0));
        rows.push_back(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH, 32'h0000_00CF, 3'd0));
        // store to a clean superpage: A/D write-back, then its response
        rows.push_back(item_row(ACT_TRANSLATE, 32'hABCD_E123, ACC_STORE, 32'h0, 3'd0));
        rows.push_back(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH, 32'h1000_0007, 3'd0));
        rows.push_back(item_row(ACT_WRITE_RSP, 32'h0, ACC_FETCH, 32'h0, 3'd0));
        // same, but the write-back hits a bus error
        rows.push_back(item_row(ACT_TRANSLATE, 32'h0000_0FFF, ACC_STORE, 32'h0, 3'd0));
        rows.push_back(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH, 32'h1000_0007, 3'd0));
        rows.push_back(known_row(item_row(ACT_WRITE_RSP, 32'h0, ACC_FETCH, 32'h0, 3'd5),
                                 KIND_DONE, '0, ST_ACCESS_FAULT, '0, 3'd5));
        // W without R
        rows.push_back(item_row(ACT_TRANSLATE, 32'hFFFF_FFFF, ACC_FETCH, 32'h0, 3'd0));
        rows.push_back(known_row(item_row(ACT_READ_RSP, 32'h0, ACC_FETCH,
                                          32'h0000_0005, 3'd0),
                                 KIND_DONE, '0, ST_PAGE_FAULT, '0, '0));

        foreach (rows[i])
        begin
            if (rows[i].is_reg)
                write_reg(rows[i].reg_idx, rows[i].reg_val);
            else
                send_item(rows[i].item, rows[i].known, rows[i].want);
        end

        // -- random phases ---------------------------------------------------
        // Phase 0 is all minimums but xlate_en, 1 and 2 push the privilege
        // extremes through MPRV, the rest are random. Each phase ends with the
        // walker back in idle, so the next register writes land between walks.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    cp = 2'd0; en = 1'b1; root = '0; s = 1'b0; m = 1'b0;
                    mp = 1'b0; pp = 2'd0;
                end
                1:
                begin
                    cp = 2'd3; en = 1'b1; root = '1; s = 1'b1; m = 1'b1;
                    mp = 1'b1; pp = 2'd1;
                end
                2:
                begin
                    cp = 2'd1; en = 1'b1; root = 22'h20_0000; s = 1'b1; m = 1'b0;
                    mp = 1'b1; pp = 2'd3;
                end
                default:
                begin
                    cp   = 2'($urandom_range(0, 3));
                    en   = ($urandom_range(0, 5) != 0);
                    root = PPN_W'($urandom);
                    s    = 1'($urandom);
                    m    = 1'($urandom);
                    mp   = 1'($urandom);
                    pp   = 2'($urandom_range(0, 3));
                end
            endcase
            write_reg(REG_CUR_PRIV,  CFG_DATA_W'(cp));
            write_reg(REG_XLATE_EN,  CFG_DATA_W'(en));
            write_reg(REG_ROOT_PPN,  CFG_DATA_W'(root));
            write_reg(REG_SUM,       CFG_DATA_W'(s));
            write_reg(REG_MXR,       CFG_DATA_W'(m));
            write_reg(REG_MPRV,      CFG_DATA_W'(mp));
            write_reg(REG_PREV_PRIV, CFG_DATA_W'(pp));

            calm   = (ph % 4 == 3);
            target = useful_items + ITEMS_PER_PHASE;
            while (useful_items < target || walk_phase != PH_IDLE)
                send_item(pick_item(useful_items < target), 1'b0, none);
        end

        // -- wind down -------------------------------------------------------
        req_if.valid <= 1'b0;
        while (walk_results_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (walk_results_due.size() != 0)
            report_mismatch("results never delivered", 64'(walk_results_due.size()), '0);

        $display("covered %0d requests (%0d in order), %0d register writes, %0d results",
                 items_in, useful_items, reg_writes, results_out);
        $display("%0d PTE reads, %0d A/D write-backs, %0d done (%0d page, %0d access %s",
                 kind_seen[KIND_READ], kind_seen[KIND_WRITE], kind_seen[KIND_DONE],
                 page_faults, access_faults, "faults)");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
